FILE: rtl/gtri_pkg.sv
// ----------------------------------------------------------------------------
// gtri_pkg
// Shared constants, codes and types of the grid triangle interpolation core.
// ----------------------------------------------------------------------------
package gtri_pkg;

    // Grid store size
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);

    // Field widths
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 18;
    localparam int INT_W     = COORD_W - FRAC_BITS;
    localparam int DIM_W     = 11;
    localparam int HEIGHT_W  = 16;
    localparam int WADDR_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Blend arithmetic widths
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int PROD_W = DIFF_W + WGT_W;
    localparam int SUM_W  = PROD_W + 1;

    // Register reset values
    localparam logic [DIM_W-1:0]    COLUMNS_RESET = DIM_W'(1024);
    localparam logic [DIM_W-1:0]    ROWS_RESET    = DIM_W'(1024);
    localparam logic [HEIGHT_W-1:0] MARKER_RESET  = HEIGHT_W'(-1000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 2'd2;

    // Item action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic                 valid;
        logic                 query;
        logic                 write_ok;
        logic                 oog;
        logic                 interp;
        logic                 lower;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_item_ctl;

endpackage

FILE: rtl/gtri_addr.sv
// ----------------------------------------------------------------------------
// gtri_addr
// Cell decode and corner address generation, two register stages.
// ----------------------------------------------------------------------------
module gtri_addr
    import gtri_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_action,
    input  logic [WADDR_W-1:0]  i_write_address,
    input  logic [HEIGHT_W-1:0] i_write_height,
    input  logic [COORD_W-1:0]  i_x_coord,
    input  logic [COORD_W-1:0]  i_y_coord,
    input  logic [DIM_W-1:0]    i_columns,
    input  logic [DIM_W-1:0]    i_rows,
    output t_item_ctl           o_ctl,
    output logic [ADDR_W-1:0]   o_addr0,
    output logic [ADDR_W-1:0]   o_addr1,
    output logic [ADDR_W-1:0]   o_addr2,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [HEIGHT_W-1:0] o_wdata
);

    logic [DIM_W-1:0]         cols;
    logic [DIM_W-1:0]         rows;
    logic [INT_W-1:0]         cx;
    logic [INT_W-1:0]         cy;
    logic [INT_W+DIM_W-1:0]   base_full;
    t_item_ctl                n_a_ctl;

    t_item_ctl                r_a_ctl;
    logic [ADDR_W-1:0]        r_a_base;
    logic [DIM_W-1:0]         r_a_cols;
    logic [ADDR_W-1:0]        r_a_waddr;
    logic [HEIGHT_W-1:0]      r_a_wdata;

    t_item_ctl                r_b_ctl;
    logic [ADDR_W-1:0]        r_b_addr0;
    logic [ADDR_W-1:0]        r_b_addr1;
    logic [ADDR_W-1:0]        r_b_addr2;
    logic [ADDR_W-1:0]        r_b_waddr;
    logic [HEIGHT_W-1:0]      r_b_wdata;

    // Stage A: decode the cell
    always_comb begin
        cols = (i_columns > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : i_columns;
        rows = (i_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : i_rows;
        cx   = i_x_coord[COORD_W-1:FRAC_BITS];
        cy   = i_y_coord[COORD_W-1:FRAC_BITS];
        base_full = cy * cols + (INT_W+DIM_W)'(cx);

        n_a_ctl.valid    = i_valid;
        n_a_ctl.query    = (i_action == ACT_QUERY);
        n_a_ctl.write_ok = ({1'b0, i_write_address} < (WADDR_W+1)'(GRID_DEPTH));
        n_a_ctl.oog      = (DIM_W'(cx) >= cols) || (DIM_W'(cy) >= rows);
        n_a_ctl.fx       = i_x_coord[FRAC_BITS-1:0];
        n_a_ctl.fy       = i_y_coord[FRAC_BITS-1:0];
        n_a_ctl.interp   = ((n_a_ctl.fx != '0) || (n_a_ctl.fy != '0))
                         && ((DIM_W'(cx) + DIM_W'(1)) < cols)
                         && ((DIM_W'(cy) + DIM_W'(1)) < rows);
        n_a_ctl.lower    = (n_a_ctl.fx > n_a_ctl.fy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_base  <= base_full[ADDR_W-1:0];
            r_a_cols  <= cols;
            r_a_waddr <= i_write_address[ADDR_W-1:0];
            r_a_wdata <= i_write_height;
        end
    end

    // Stage B: neighbor addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_addr0 <= r_a_base;
            r_b_addr1 <= r_a_ctl.lower ? r_a_base + ADDR_W'(1)
                                       : r_a_base + ADDR_W'(r_a_cols);
            r_b_addr2 <= r_a_base + ADDR_W'(r_a_cols) + ADDR_W'(1);
            r_b_waddr <= r_a_waddr;
            r_b_wdata <= r_a_wdata;
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_addr0 = r_b_addr0;
    assign o_addr1 = r_b_addr1;
    assign o_addr2 = r_b_addr2;
    assign o_waddr = r_b_waddr;
    assign o_wdata = r_b_wdata;

endmodule

FILE: rtl/gtri_grid_mem.sv
// ----------------------------------------------------------------------------
// gtri_grid_mem
// Height grid store: two copies, three corner reads per cycle while enabled.
// ----------------------------------------------------------------------------
module gtri_grid_mem
    import gtri_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_item_ctl           i_ctl,
    input  logic [ADDR_W-1:0]   i_addr0,
    input  logic [ADDR_W-1:0]   i_addr1,
    input  logic [ADDR_W-1:0]   i_addr2,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [HEIGHT_W-1:0] i_wdata,
    output t_item_ctl           o_ctl,
    output logic [HEIGHT_W-1:0] o_h0,
    output logic [HEIGHT_W-1:0] o_h1,
    output logic [HEIGHT_W-1:0] o_h2
);

    // Copy A: one write, two reads. Copy B: one write, one read.
    logic [HEIGHT_W-1:0] mem_a [GRID_DEPTH];
    logic [HEIGHT_W-1:0] mem_b [GRID_DEPTH];

    logic                wen;
    t_item_ctl           r_ctl;
    logic [HEIGHT_W-1:0] r_h0;
    logic [HEIGHT_W-1:0] r_h1;
    logic [HEIGHT_W-1:0] r_h2;

    assign wen = i_en && i_ctl.valid && !i_ctl.query && i_ctl.write_ok;

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem_a[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_h0 <= mem_a[i_addr0];
            r_h1 <= mem_a[i_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem_b[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_h2 <= mem_b[i_addr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    assign o_ctl = r_ctl;
    assign o_h0  = r_h0;
    assign o_h1  = r_h1;
    assign o_h2  = r_h2;

endmodule

FILE: rtl/gtri_blend.sv
// ----------------------------------------------------------------------------
// gtri_blend
// Triangle blend: weight products, then shift, add, select and result register.
// ----------------------------------------------------------------------------
module gtri_blend
    import gtri_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_item_ctl           i_ctl,
    input  logic [HEIGHT_W-1:0] i_h0,
    input  logic [HEIGHT_W-1:0] i_h1,
    input  logic [HEIGHT_W-1:0] i_h2,
    input  logic [HEIGHT_W-1:0] i_marker,
    output logic                o_valid,
    output logic [HEIGHT_W-1:0] o_height,
    output logic                o_out_of_grid
);

    // Both triangles share one form: h0 + (wa*(hb-h0) - wb*(hb-hc)) >>> 8
    logic [FRAC_BITS-1:0]       wa;
    logic [FRAC_BITS-1:0]       wb;
    logic signed [DIFF_W-1:0]   d1;
    logic signed [DIFF_W-1:0]   d2;
    logic signed [PROD_W-1:0]   n_p1;
    logic signed [PROD_W-1:0]   n_p2;
    logic signed [SUM_W-1:0]    v;
    logic signed [SUM_W-1:0]    v_sh;
    logic signed [HEIGHT_W-1:0] blend;
    logic [HEIGHT_W-1:0]        n_height;

    t_item_ctl                  r_d_ctl;
    logic signed [HEIGHT_W-1:0] r_d_h0;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [PROD_W-1:0]   r_p2;

    logic                       r_valid;
    logic [HEIGHT_W-1:0]        r_height;
    logic                       r_oog;

    // Stage D: products
    always_comb begin
        wa   = i_ctl.lower ? i_ctl.fx : i_ctl.fy;
        wb   = i_ctl.lower ? i_ctl.fy : i_ctl.fx;
        d1   = DIFF_W'($signed(i_h1)) - DIFF_W'($signed(i_h0));
        d2   = DIFF_W'($signed(i_h1)) - DIFF_W'($signed(i_h2));
        n_p1 = $signed({1'b0, wa}) * d1;
        n_p2 = $signed({1'b0, wb}) * d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (i_en) begin
            r_d_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_h0 <= $signed(i_h0);
            r_p1   <= n_p1;
            r_p2   <= n_p2;
        end
    end

    // Stage E: floor shift, add, select
    always_comb begin
        v     = SUM_W'(r_p1) - SUM_W'(r_p2);
        v_sh  = v >>> FRAC_BITS;
        blend = r_d_h0 + HEIGHT_W'(v_sh);
        if (r_d_ctl.oog) begin
            n_height = i_marker;
        end else if (r_d_ctl.interp) begin
            n_height = blend;
        end else begin
            n_height = r_d_h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_d_ctl.valid && r_d_ctl.query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_height <= n_height;
            r_oog    <= r_d_ctl.oog;
        end
    end

    assign o_valid       = r_valid;
    assign o_height      = r_height;
    assign o_out_of_grid = r_oog;

endmodule

FILE: rtl/grid_triangle_interpolation_core.sv
// ----------------------------------------------------------------------------
// grid_triangle_interpolation_core
// Elevation grid with triangle interpolation of 10.8 fixed-point queries.
// ----------------------------------------------------------------------------
// A query result passes the registers of stages A to E in turn.
// Throughput: one item per cycle while the output is not stalled; the grid store keeps two copies so that
//   all three corner reads and a write fit one memory stage.
// Reset: clears pipeline valid bits and the registers (1024 columns,
//   1024 rows, marker -1000). Grid contents are not cleared.
// ----------------------------------------------------------------------------
module grid_triangle_interpolation_core
    import gtri_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [WADDR_W-1:0]    i_write_address,
    input  logic [HEIGHT_W-1:0]   i_write_height,
    input  logic [COORD_W-1:0]    i_x_coord,
    input  logic [COORD_W-1:0]    i_y_coord,
    // Result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [HEIGHT_W-1:0]   o_height,
    output logic                  o_out_of_grid,
    // Register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Pipeline:
    //   A  cell decode, range checks, base = row*columns + column
    //   B  neighbor addresses (right or lower, and diagonal)
    //   C  grid reads, and the write of a write item
    //   D  corner differences times fraction weights
    //   E  floor shift by 8, add base corner, select, result register
    // All stages move together; the pipe holds only while a finished
    // result sits in the output register and the consumer stalls.

    logic [DIM_W-1:0]    r_columns;
    logic [DIM_W-1:0]    r_rows;
    logic [HEIGHT_W-1:0] r_marker;

    logic                en;
    logic                out_valid;

    t_item_ctl           b_ctl;
    logic [ADDR_W-1:0]   b_addr0;
    logic [ADDR_W-1:0]   b_addr1;
    logic [ADDR_W-1:0]   b_addr2;
    logic [ADDR_W-1:0]   b_waddr;
    logic [HEIGHT_W-1:0] b_wdata;

    t_item_ctl           c_ctl;
    logic [HEIGHT_W-1:0] c_h0;
    logic [HEIGHT_W-1:0] c_h1;
    logic [HEIGHT_W-1:0] c_h2;

    // Writes must arrive only while idle (the block does not enforce it); registers are always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
            r_marker  <= MARKER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: r_columns <= i_cfg_data[DIM_W-1:0];
                CFG_ROWS:    r_rows    <= i_cfg_data[DIM_W-1:0];
                CFG_MARKER:  r_marker  <= i_cfg_data[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Global advance: hold only when the output item is not taken.
    assign en      = !(out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = out_valid;

    gtri_addr u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_action        (i_action),
        .i_write_address (i_write_address),
        .i_write_height  (i_write_height),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_columns       (r_columns),
        .i_rows          (r_rows),
        .o_ctl           (b_ctl),
        .o_addr0         (b_addr0),
        .o_addr1         (b_addr1),
        .o_addr2         (b_addr2),
        .o_waddr         (b_waddr),
        .o_wdata         (b_wdata)
    );

    gtri_grid_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (b_ctl),
        .i_addr0 (b_addr0),
        .i_addr1 (b_addr1),
        .i_addr2 (b_addr2),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .o_ctl   (c_ctl),
        .o_h0    (c_h0),
        .o_h1    (c_h1),
        .o_h2    (c_h2)
    );

    gtri_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_ctl         (c_ctl),
        .i_h0          (c_h0),
        .i_h1          (c_h1),
        .i_h2          (c_h2),
        .i_marker      (r_marker),
        .o_valid       (out_valid),
        .o_height      (o_height),
        .o_out_of_grid (o_out_of_grid)
    );

endmodule

FILE: rtl/gtri_checker.sv
// ----------------------------------------------------------------------------
// gtri_checker
// Port-level assertions for the grid triangle interpolation core.
// ----------------------------------------------------------------------------
module gtri_checker
    import gtri_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                i_action,
    input logic                o_valid,
    input logic                i_stall,
    input logic [HEIGHT_W-1:0] o_height,
    input logic                o_out_of_grid
);

    logic adv;
    logic query_acc;

    assign adv       = i_rst_n && !o_stall;
    assign query_acc = adv && i_valid && (i_action == ACT_QUERY);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input is held back only by a result that waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // A waiting result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_height)
                                  && $stable(o_out_of_grid)))
        else $error("stalled result changed");

    // A query with a free-running pipe gives its result once it has passed stages A to E
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(query_acc, 5) && $past(adv, 4) && $past(adv, 3)
         && $past(adv, 2) && $past(adv, 1)) |-> o_valid)
        else $error("query result missing after pipeline latency");

endmodule

bind grid_triangle_interpolation_core gtri_checker u_gtri_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_height      (o_height),
    .o_out_of_grid (o_out_of_grid)
);
